/* rtl/core/wwts_pkg.sv */
// ----------------------------------------------------------------------------
// wwts_pkg
// Shared types and constants of the weekly window timer switch.
// ----------------------------------------------------------------------------
package wwts_pkg;

	// Time of day in seconds; a raw hour of 31 still fits.
	localparam int unsigned TIME_W     = 17;
	localparam int unsigned END_SUM_W  = TIME_W + 1;
	localparam int unsigned HOUR_W     = 5;
	localparam int unsigned MINUTE_W   = 6;
	localparam int unsigned SECOND_W   = 6;
	localparam int unsigned WEEKDAY_W  = 3;
	localparam int unsigned SKIP_DAY_W = 4;
	localparam int unsigned DAYMASK_W  = 7;

	localparam logic [TIME_W-1:0]    SECS_PER_HOUR   = TIME_W'(3600);
	localparam logic [TIME_W-1:0]    SECS_PER_MINUTE = TIME_W'(60);
	localparam logic [TIME_W-1:0]    DAY_LAST_SEC    = TIME_W'(86399);
	localparam logic [END_SUM_W-1:0] SECS_PER_DAY    = END_SUM_W'(86400);

	// Skip day code for "no day skipped".
	localparam logic [SKIP_DAY_W-1:0] NO_DAY = SKIP_DAY_W'(8);
	// Weekday that no window mask can enable.
	localparam logic [WEEKDAY_W-1:0]  WEEKDAY_NONE = WEEKDAY_W'(7);

	// Window register packing.
	localparam int unsigned WIN_W         = 41;
	localparam int unsigned WIN_START_LSB = 0;
	localparam int unsigned WIN_DUR_LSB   = 17;
	localparam int unsigned WIN_DAYS_LSB  = 34;
	localparam int unsigned WIN_FIELD_W   = 17;

	localparam int unsigned MAX_WINDOWS_DEF = 4;
	localparam int unsigned ACT_W           = 4;
	localparam int unsigned USE_W           = 3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_0       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_IN_USE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_LEVEL       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PERM_OFF       = 3'd6;

	// Per-window decision handed to the top level.
	typedef struct packed {
		logic clr;   // active window ran past its end: clear and ask for off
		logic set;   // idle window is inside its span: set and ask for on
	} wwts_hit_t;

	// Window context shared by every window evaluator.
	typedef struct packed {
		logic [TIME_W-1:0]    t;
		logic [WEEKDAY_W-1:0] weekday;
		logic                 was_on;
	} wwts_tick_t;

endpackage

/* rtl/core/wwts_window.sv */
// ----------------------------------------------------------------------------
// wwts_window
// Evaluates one switching window against the current tick.
// ----------------------------------------------------------------------------
module wwts_window (
	input  logic [wwts_pkg::WIN_W-1:0] window_cfg,
	input  logic                       in_use,
	input  logic                       active,
	input  wwts_pkg::wwts_tick_t       tick,
	output wwts_pkg::wwts_hit_t        hit
);
	import wwts_pkg::*;

	logic [WIN_FIELD_W-1:0] start_raw;
	logic [WIN_FIELD_W-1:0] dur_raw;
	logic [DAYMASK_W-1:0]   days;
	logic [TIME_W-1:0]      start_sec;
	logic [TIME_W-1:0]      dur_sec;
	logic [END_SUM_W-1:0]   end_sum;
	logic [TIME_W-1:0]      end_sec;
	logic [DAYMASK_W:0]     days_ext;
	logic                   today;

	assign start_raw = window_cfg[WIN_START_LSB +: WIN_FIELD_W];
	assign dur_raw   = window_cfg[WIN_DUR_LSB +: WIN_FIELD_W];
	assign days      = window_cfg[WIN_DAYS_LSB +: DAYMASK_W];

	// Clamp oversized fields to the last second of the day.
	assign start_sec = (start_raw > DAY_LAST_SEC) ? DAY_LAST_SEC : start_raw;
	assign dur_sec   = (dur_raw > DAY_LAST_SEC) ? DAY_LAST_SEC : dur_raw;

	// Wrap the end past midnight; the sum stays below two days.
	assign end_sum = {1'b0, start_sec} + {1'b0, dur_sec};
	assign end_sec = (end_sum >= SECS_PER_DAY) ? TIME_W'(end_sum - SECS_PER_DAY)
	                                           : end_sum[TIME_W-1:0];

	assign days_ext = {1'b0, days};
	assign today    = (tick.weekday != WEEKDAY_NONE) && days_ext[tick.weekday];

	always_comb begin
		hit.clr = in_use && active && (tick.t > end_sec) && today && tick.was_on;
		hit.set = in_use && !active && (tick.t > start_sec) && (tick.t < end_sec)
		          && today && !tick.was_on;
	end

endmodule

/* rtl/core/weekly_window_timer_switch_core.sv */
// ----------------------------------------------------------------------------
// weekly_window_timer_switch_core
// Weekly programmable timer switch: time ticks in, load state out.
// ----------------------------------------------------------------------------
// Each accepted item is one time tick (hour, minute, second, weekday and a
// skip-today request) and yields exactly one result item: load state, pin
// level, skip status and the active bit of every window. The block takes one
// item per clock cycle while the result port is not stalled. A taken item is
// loaded into the input register, passes the window compare logic, and its
// result is loaded into the result register, which offers it. A stalled
// result port holds the result register and, once the input register is full
// too, drops in_ready. Program
// window_0..window_3, windows_in_use, on_level and permanently_off through
// the configuration port while no item is in flight; cfg_ready is always high
// and writes to an index beyond the list are ignored. Window registers above
// MAX_WINDOWS are not built and writes to them are ignored.
// ----------------------------------------------------------------------------
module weekly_window_timer_switch_core #(
	parameter int unsigned MAX_WINDOWS = wwts_pkg::MAX_WINDOWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tick channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [wwts_pkg::HOUR_W-1:0]         hour_now,
	input  logic [wwts_pkg::MINUTE_W-1:0]       minute_now,
	input  logic [wwts_pkg::SECOND_W-1:0]       second_now,
	input  logic [wwts_pkg::WEEKDAY_W-1:0]      weekday_now,
	input  logic                                skip_today,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                load_on,
	output logic                                pin_level,
	output logic                                day_skipped,
	output logic [wwts_pkg::ACT_W-1:0]          active_windows,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wwts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wwts_pkg::WIN_W-1:0]          cfg_data
);
	import wwts_pkg::*;

	// Configuration registers
	logic [WIN_W-1:0] window_q [MAX_WINDOWS];
	logic [USE_W-1:0] windows_in_use_q;
	logic             on_level_q;
	logic             perm_off_q;

	// Switch state. A skip request is always consumed in the tick that
	// brings it, so no pending flag survives between ticks.
	logic                  output_on_q;
	logic                  skip_active_q;
	logic [SKIP_DAY_W-1:0] skip_weekday_q;
	logic [MAX_WINDOWS-1:0] active_q;

	// Input register
	logic                 valid_s1;
	logic [HOUR_W-1:0]    hour_s1;
	logic [MINUTE_W-1:0]  minute_s1;
	logic [SECOND_W-1:0]  second_s1;
	logic [WEEKDAY_W-1:0] weekday_s1;
	logic                 skip_s1;

	// Result register
	logic             valid_s2;
	logic             load_on_s2;
	logic             pin_level_s2;
	logic             day_skipped_s2;
	logic [ACT_W-1:0] active_s2;

	logic in_fire;
	logic advance;

	// Tick evaluation
	logic                   skip_start;
	logic                   skip_end;
	logic                   on_after_skip;
	logic                   skip_active_n;
	logic [SKIP_DAY_W-1:0]  skip_weekday_n;
	logic [SKIP_DAY_W-1:0]  weekday_ext;
	wwts_tick_t             tick;
	wwts_hit_t              hit [MAX_WINDOWS];
	logic [MAX_WINDOWS-1:0] clr_vec;
	logic [MAX_WINDOWS-1:0] set_vec;
	logic [MAX_WINDOWS-1:0] active_n;
	logic                   request;
	logic                   output_on_n;
	logic [ACT_W-1:0]       active_out;

	// Handshakes: advance whenever the result register is empty or drained.
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			windows_in_use_q <= '0;
			on_level_q       <= 1'b1;
			perm_off_q       <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WINDOWS_IN_USE: windows_in_use_q <= cfg_data[USE_W-1:0];
				CFG_ON_LEVEL:       on_level_q       <= cfg_data[0];
				CFG_PERM_OFF:       perm_off_q       <= cfg_data[0];
				default:            ;
			endcase
		end
	end

	for (genvar gi = 0; gi < MAX_WINDOWS; gi++) begin : g_win_cfg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				window_q[gi] <= '0;
			end else if (cfg_valid && (cfg_index == CFG_WINDOW_0 + CFG_IDX_W'(gi))) begin
				window_q[gi] <= cfg_data;
			end
		end
	end

	// Input register: hold the tick until the result register can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hour_s1    <= hour_now;
			minute_s1  <= minute_now;
			second_s1  <= second_now;
			weekday_s1 <= weekday_now;
			skip_s1    <= skip_today;
		end
	end

	// Skip handling: a skip request, or reaching the stored skip day again,
	// forces the load off; a new weekday ends the skip.
	assign weekday_ext = {1'b0, weekday_s1};
	assign skip_start  = skip_s1 || (!skip_active_q && (skip_weekday_q == weekday_ext));
	assign skip_end    = !skip_start && skip_active_q && (skip_weekday_q != weekday_ext);

	always_comb begin
		on_after_skip  = output_on_q;
		skip_active_n  = skip_active_q;
		skip_weekday_n = skip_weekday_q;
		if (skip_start) begin
			on_after_skip  = 1'b0;
			skip_active_n  = 1'b1;
			skip_weekday_n = weekday_ext;
		end else if (skip_end) begin
			skip_active_n  = 1'b0;
			skip_weekday_n = NO_DAY;
		end
	end

	// Time of day in seconds, formed from the raw fields without wrapping.
	assign tick.t = TIME_W'(hour_s1) * SECS_PER_HOUR
	              + TIME_W'(minute_s1) * SECS_PER_MINUTE
	              + TIME_W'(second_s1);
	assign tick.weekday = weekday_s1;
	assign tick.was_on  = on_after_skip;

	// All windows see the same load state, so windows only clear while the
	// load is on and only set while it is off; the last request then reduces
	// to "any clear" or "any set".
	for (genvar gi = 0; gi < MAX_WINDOWS; gi++) begin : g_win
		wwts_window u_window (
			.window_cfg (window_q[gi]),
			.in_use     (windows_in_use_q > USE_W'(gi)),
			.active     (active_q[gi]),
			.tick       (tick),
			.hit        (hit[gi])
		);
		assign clr_vec[gi]  = hit[gi].clr;
		assign set_vec[gi]  = hit[gi].set;
		assign active_n[gi] = (active_q[gi] && !hit[gi].clr) || hit[gi].set;
	end

	assign request = on_after_skip ? !(|clr_vec) : (|set_vec);

	// Honor a turn-on only when allowed; a refused turn-on keeps the state.
	assign output_on_n = request && (on_after_skip || (!perm_off_q && !skip_active_n));

	always_comb begin
		active_out = '0;
		active_out[MAX_WINDOWS-1:0] = active_n;
	end

	// State update and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			output_on_q    <= 1'b0;
			skip_active_q  <= 1'b0;
			skip_weekday_q <= NO_DAY;
			active_q       <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				output_on_q    <= output_on_n;
				skip_active_q  <= skip_active_n;
				skip_weekday_q <= skip_weekday_n;
				active_q       <= active_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			load_on_s2     <= output_on_n;
			pin_level_s2   <= output_on_n ? on_level_q : !on_level_q;
			day_skipped_s2 <= skip_active_n;
			active_s2      <= active_out;
		end
	end

	assign out_valid      = valid_s2;
	assign load_on        = load_on_s2;
	assign pin_level      = pin_level_s2;
	assign day_skipped    = day_skipped_s2;
	assign active_windows = active_s2;

endmodule

/* rtl/core/wwts_checker.sv */
// ----------------------------------------------------------------------------
// wwts_checker
// Port-level checks of the weekly window timer switch.
// ----------------------------------------------------------------------------
module wwts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           load_on,
	input logic                           pin_level,
	input logic                           day_skipped,
	input logic [wwts_pkg::ACT_W-1:0]     active_windows
);
	import wwts_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(load_on) && $stable(pin_level) && $stable(day_skipped)
		&& $stable(active_windows))
		else $error("result payload changed while stalled");

	// With the result register empty, a tick is always taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// The load is never on during a skipped day.
	a_skip_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && day_skipped |-> !load_on)
		else $error("load on while day skipped");

	// The load only turns on through a window, which then stays active.
	a_on_has_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && load_on |-> (active_windows != '0))
		else $error("load on with no active window");

endmodule

bind weekly_window_timer_switch_core wwts_checker u_wwts_checker (.*);
